>>> rtl/pixel_format_to_argb_gamma_top_defines.svh
// Assertion macros shared by the pixel format converter RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PIXEL_FORMAT_TO_ARGB_GAMMA_TOP_DEFINES_SVH
`define PIXEL_FORMAT_TO_ARGB_GAMMA_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFAG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PFAG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pfag_pkg.sv
// Shared types, constants and the pixel conversion function of the pixel
// format converter. No dependencies.
`default_nettype none

package pfag_pkg;

    localparam int unsigned ADDR_W     = 18;
    localparam int unsigned COUNT_W    = 10;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned FMT_W      = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned POS_W      = 9;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_FORMAT = 3'd0,
        CFG_LINE_MODE    = 3'd1,
        CFG_RECT_X       = 3'd2,
        CFG_RECT_Y       = 3'd3,
        CFG_RECT_W       = 3'd4,
        CFG_RECT_H       = 3'd5,
        CFG_ROW_PITCH    = 3'd6,
        CFG_GAMMA_ENABLE = 3'd7
    } cfg_reg_t;

    // Source pixel formats.
    typedef logic [FMT_W-1:0] fmt_t;
    localparam fmt_t FMT_BGR565   = 4'd0;
    localparam fmt_t FMT_BGR555   = 4'd1;
    localparam fmt_t FMT_BGR444   = 4'd2;
    localparam fmt_t FMT_ABGR8888 = 4'd3;

    // Input item kinds carried on tuser.
    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_GAMMA = 1'b1;

    localparam logic [31:0] ALPHA_OPAQUE   = 32'hFF00_0000;
    localparam logic [31:0] REP565_RB_MASK = 32'h00E0_00E0;
    localparam logic [31:0] REP565_G_MASK  = 32'h0000_C000;
    localparam logic [31:0] REP555_MASK    = 32'h00E0_E0E0;
    localparam logic [31:0] REP444_MASK    = 32'h00F0_F0F0;

    // Rectangle geometry handed to the address generator.
    typedef struct packed {
        logic [ADDR_W-1:0]  base;        // first texel of the frame
        logic [COUNT_W:0]   step_pitch;  // address step between used rows
        logic [COUNT_W-1:0] rect_w;
        logic [COUNT_W-1:0] rect_h;
        logic               skip;        // advance two rows per source row
    } geom_t;

    // Address generator result for one pixel.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              last;
    } addr_res_t;

    // True for the 16-bit source formats.
    function automatic logic is_16bit(fmt_t fmt);
        return fmt inside {FMT_BGR565, FMT_BGR555, FMT_BGR444};
    endfunction

    // True for every known format.
    function automatic logic is_known(fmt_t fmt);
        return fmt inside {FMT_BGR565, FMT_BGR555, FMT_BGR444, FMT_ABGR8888};
    endfunction

    // Widens a source pixel to ARGB8888 with opaque alpha; unknown formats give zero.
    function automatic logic [31:0] convert(fmt_t fmt, logic [31:0] word);
        logic [31:0] s;
        logic [31:0] c;
        s = {16'h0000, word[15:0]};
        c = '0;
        case (fmt)
            FMT_BGR565:
            begin
                c = ((s & 32'h0000_001F) << 19) | ((s & 32'h0000_07E0) << 5)
                  | ((s & 32'h0000_F800) >> 8) | ALPHA_OPAQUE;
                c = c | ((c & REP565_RB_MASK) >> 5) | ((c & REP565_G_MASK) >> 6);
            end
            FMT_BGR555:
            begin
                c = ((s & 32'h0000_001F) << 19) | ((s & 32'h0000_03E0) << 6)
                  | ((s & 32'h0000_7C00) >> 7) | ALPHA_OPAQUE;
                c = c | ((c & REP555_MASK) >> 5);
            end
            FMT_BGR444:
            begin
                c = ((s & 32'h0000_000F) << 20) | ((s & 32'h0000_00F0) << 8)
                  | ((s & 32'h0000_0F00) >> 4) | ALPHA_OPAQUE;
                c = c | ((c & REP444_MASK) >> 4);
            end
            FMT_ABGR8888:
            begin
                c = {8'hFF, word[7:0], word[15:8], word[23:16]};
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pfag_gamma_ram.sv
// One channel bank of the gamma table: 256 x 8 bits, one write and one
// registered read port. Depends on pfag_pkg.
`default_nettype none

module pfag_gamma_ram
(
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [pfag_pkg::LEVEL_W-1:0] waddr,
    input  wire logic [pfag_pkg::LEVEL_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [pfag_pkg::LEVEL_W-1:0] raddr,
    output logic      [pfag_pkg::LEVEL_W-1:0] rdata
);

    localparam int unsigned DEPTH = 2 ** pfag_pkg::LEVEL_W;

    logic [pfag_pkg::LEVEL_W-1:0] mem [DEPTH];

    // Table write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/pfag_addr_gen.sv
// Texture address generator: column, row and row start counters that walk
// the destination rectangle. Depends on pfag_pkg and the defines header.
`default_nettype none
`include "pixel_format_to_argb_gamma_top_defines.svh"

module pfag_addr_gen
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,   // a pixel item is accepted
    input  wire pfag_pkg::geom_t   geom,
    output pfag_pkg::addr_res_t    res
);

    logic [pfag_pkg::COUNT_W-1:0] col_reg, col_next;
    logic [pfag_pkg::COUNT_W-1:0] row_reg, row_next;
    logic [pfag_pkg::ADDR_W-1:0]  row_start_reg, row_start_next;

    logic                         frame_start;
    logic [pfag_pkg::ADDR_W-1:0]  row_start_eff;
    logic [pfag_pkg::COUNT_W:0]   col_inc;
    logic [pfag_pkg::COUNT_W:0]   row_adv;
    logic                         row_end;
    logic                         frame_end;

    // Current address and end-of-row and end-of-frame tests.
    always_comb
    begin
        frame_start   = (col_reg == '0) && (row_reg == '0);
        row_start_eff = frame_start ? geom.base : row_start_reg;
        res.address   = row_start_eff + pfag_pkg::ADDR_W'(col_reg);
        col_inc       = {1'b0, col_reg} + 1'b1;
        row_end       = col_inc >= {1'b0, geom.rect_w};
        row_adv       = {1'b0, row_reg} + (geom.skip ? 11'd2 : 11'd1);
        frame_end     = row_end && (row_adv >= {1'b0, geom.rect_h});
        res.last      = frame_end;
    end

    // Counter update for each accepted pixel.
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        row_start_next = row_start_reg;
        if (step)
        begin
            if (frame_end)
            begin
                col_next       = '0;
                row_next       = '0;
                row_start_next = '0;
            end
            else if (row_end)
            begin
                col_next       = '0;
                row_next       = row_adv[pfag_pkg::COUNT_W-1:0];
                row_start_next = row_start_eff + pfag_pkg::ADDR_W'(geom.step_pitch);
            end
            else
            begin
                col_next       = col_inc[pfag_pkg::COUNT_W-1:0];
                row_start_next = row_start_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            row_start_reg <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_start_reg <= row_start_next;
        end
    end

    `PFAG_ASSERT_NEXT(a_frame_restart, step && frame_end,
        (col_reg == '0) && (row_reg == '0) && (row_start_reg == '0),
        "counters did not restart after the last texel")
    `PFAG_ASSERT_NEXT(a_col_advance, step && !row_end,
        col_reg == $past(col_reg) + 1'b1,
        "column counter did not advance within a row")

endmodule

`default_nettype wire

>>> rtl/pixel_format_to_argb_gamma_top.sv
// Pixel format converter top level: configuration registers, pixel
// conversion, gamma table banks and the output pipeline.
// Depends on pfag_pkg, pfag_gamma_ram, pfag_addr_gen and the defines header.
//
// Converts one source pixel item per clock, while the output is not stalled and
// no configuration write is pending, into an opaque ARGB8888 texel with its
// texture address; gamma write items load the 3 x 256 gamma table and give no
// result. A pixel's result passes through the stage one and output registers
// before it is presented on the output. A full pipeline sustains one item per
// cycle while m_tready stays high. After every configuration write s_tready is
// low in the following cycle while the frame start address rect_y*row_pitch+rect_x
// (plus row_pitch for 16-bit formats with line mode bit 0) is recomputed. The gamma
// table has no reset and must be loaded before gamma_enable is set.
`default_nettype none
`include "pixel_format_to_argb_gamma_top_defines.svh"

module pixel_format_to_argb_gamma_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: pixel_word[31:0], gamma_channel[33:32], gamma_index[41:34],
    //          gamma_value[49:42], zero fill[55:50]
    input  wire logic [55:0] s_tdata,
    // s_tuser: action[0]
    input  wire logic        s_tuser,
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: texel_argb[31:0], texel_address[49:32], zero fill[55:50]
    output logic [55:0]      m_tdata,
    // m_tlast: frame_last
    output logic             m_tlast
);

    localparam int unsigned LW = pfag_pkg::LEVEL_W;
    localparam int unsigned AW = pfag_pkg::ADDR_W;
    localparam int unsigned CW = pfag_pkg::COUNT_W;
    localparam int unsigned PW = pfag_pkg::POS_W;

    // Configuration registers
    pfag_pkg::fmt_t  fmt_reg;
    logic [1:0]      line_mode_reg;
    logic [PW-1:0]   rect_x_reg;
    logic [PW-1:0]   rect_y_reg;
    logic [CW-1:0]   rect_w_reg;
    logic [CW-1:0]   rect_h_reg;
    logic [CW-1:0]   row_pitch_reg;
    logic            gamma_en_reg;
    logic            cfg_pending_reg;
    logic [AW-1:0]   base_reg, base_next;

    // Input fields
    logic            action;
    logic [31:0]     pixel_word;
    logic [1:0]      gamma_channel;
    logic [LW-1:0]   gamma_index;
    logic [LW-1:0]   gamma_value;

    logic            in_accept;
    logic            pix_accept;
    logic            gam_accept;
    logic            is16;
    logic [31:0]     color;
    logic [LW-1:0]   level [pfag_pkg::NUM_CH];
    logic [LW-1:0]   gdata [pfag_pkg::NUM_CH];

    pfag_pkg::geom_t     geom;
    pfag_pkg::addr_res_t addr_res;

    // Pipeline registers
    logic            s1_valid_reg;
    logic [31:0]     s1_color_reg;
    logic            s1_gamma_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic            s1_last_reg;
    logic            out_valid_reg;
    logic [31:0]     out_argb_reg;
    logic [AW-1:0]   out_addr_reg;
    logic            out_last_reg;

    logic            out_free;
    logic            s1_advance;
    logic [31:0]     s1_texel;
    logic [2*CW-1:0] base_prod;
    logic [AW+1:0]   base_sum;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg         <= pfag_pkg::FMT_BGR565;
            line_mode_reg   <= '0;
            rect_x_reg      <= '0;
            rect_y_reg      <= '0;
            rect_w_reg      <= 10'd480;
            rect_h_reg      <= 10'd272;
            row_pitch_reg   <= 10'd512;
            gamma_en_reg    <= 1'b0;
            cfg_pending_reg <= 1'b0;
            base_reg        <= '0;
        end
        else
        begin
            cfg_pending_reg <= cfg_we;
            base_reg        <= base_next;
            if (cfg_we)
            begin
                case (pfag_pkg::cfg_reg_t'(cfg_index))
                    pfag_pkg::CFG_PIXEL_FORMAT: fmt_reg       <= cfg_data[3:0];
                    pfag_pkg::CFG_LINE_MODE:    line_mode_reg <= cfg_data[1:0];
                    pfag_pkg::CFG_RECT_X:       rect_x_reg    <= cfg_data[PW-1:0];
                    pfag_pkg::CFG_RECT_Y:       rect_y_reg    <= cfg_data[PW-1:0];
                    pfag_pkg::CFG_RECT_W:       rect_w_reg    <= cfg_data;
                    pfag_pkg::CFG_RECT_H:       rect_h_reg    <= cfg_data;
                    pfag_pkg::CFG_ROW_PITCH:    row_pitch_reg <= cfg_data;
                    pfag_pkg::CFG_GAMMA_ENABLE: gamma_en_reg  <= cfg_data[0];
                    default:                    gamma_en_reg  <= gamma_en_reg;
                endcase
            end
        end
    end

    // Frame start address and rectangle geometry.
    always_comb
    begin
        is16      = pfag_pkg::is_16bit(fmt_reg);
        base_prod = {1'b0, rect_y_reg} * row_pitch_reg;
        base_sum  = (AW+2)'(base_prod) + (AW+2)'(rect_x_reg)
                  + ((is16 && line_mode_reg[0]) ? (AW+2)'(row_pitch_reg) : '0);
        base_next = base_sum[AW-1:0];

        geom.base       = base_reg;
        geom.skip       = is16 && line_mode_reg[1];
        geom.step_pitch = geom.skip ? {row_pitch_reg, 1'b0} : {1'b0, row_pitch_reg};
        geom.rect_w     = rect_w_reg;
        geom.rect_h     = rect_h_reg;
    end

    // Input unpacking and handshake.
    always_comb
    begin
        action        = s_tuser;
        pixel_word    = s_tdata[31:0];
        gamma_channel = s_tdata[33:32];
        gamma_index   = s_tdata[41:34];
        gamma_value   = s_tdata[49:42];

        out_free   = !out_valid_reg || m_tready;
        s1_advance = s1_valid_reg && out_free;
        s_tready   = !cfg_pending_reg && (!s1_valid_reg || out_free);
        in_accept  = s_tvalid && s_tready;
        pix_accept = in_accept && (action == pfag_pkg::ACTION_PIXEL);
        gam_accept = in_accept && (action == pfag_pkg::ACTION_GAMMA);

        color    = pfag_pkg::convert(fmt_reg, pixel_word);
        level[0] = color[23:16];
        level[1] = color[15:8];
        level[2] = color[7:0];
    end

    // Gamma table banks: red, green, blue.
    for (genvar g = 0; g < pfag_pkg::NUM_CH; g++)
    begin : g_bank
        pfag_gamma_ram u_bank
        (
            .clk   (clk),
            .we    (gam_accept && (gamma_channel == 2'(g))),
            .waddr (gamma_index),
            .wdata (gamma_value),
            .re    (pix_accept),
            .raddr (level[g]),
            .rdata (gdata[g])
        );
    end

    pfag_addr_gen u_addr
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (pix_accept),
        .geom  (geom),
        .res   (addr_res)
    );

    // Stage one: waits for the gamma read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_color_reg <= color;
            s1_gamma_reg <= gamma_en_reg && pfag_pkg::is_known(fmt_reg);
            s1_addr_reg  <= addr_res.address;
            s1_last_reg  <= addr_res.last;
        end
    end

    assign s1_texel = s1_gamma_reg ? {8'hFF, gdata[0], gdata[1], gdata[2]} : s1_color_reg;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_argb_reg <= s1_texel;
            out_addr_reg <= s1_addr_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_addr_reg, out_argb_reg};
    assign m_tlast  = out_last_reg;

    `PFAG_ASSERT_NEXT(a_cfg_holdoff, cfg_we, !s_tready,
        "input accepted right after a configuration write")
    `PFAG_ASSERT_NEXT(a_pix_enters, pix_accept, s1_valid_reg,
        "accepted pixel did not enter stage one")
    `PFAG_ASSERT_NEXT(a_s1_holds, s1_valid_reg && !out_free,
        s1_valid_reg && $stable(s1_addr_reg),
        "stage one lost its item during a stall")
    `PFAG_ASSERT_SAME(a_no_overrun, pix_accept && s1_valid_reg, s1_advance,
        "pixel accepted into a full stage one")

endmodule

`default_nettype wire

>>> sim/pfag_checker.sv
// Checker for the pixel format converter: watches the register port and both streams,
// predicts every texel and compares it field by field with what the block emits.
// Depends on pfag_pkg for the register indexes, format codes and item kinds.
`default_nettype none

module pfag_checker
    import pfag_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // s_tdata: pixel_word[31:0], gamma_channel[33:32], gamma_index[41:34],
    //          gamma_value[49:42], zero fill[55:50]
    input  wire logic [55:0] s_tdata,
    // s_tuser: action[0]
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: texel_argb[31:0], texel_address[49:32], zero fill[55:50]
    input  wire logic [55:0] m_tdata,
    input  wire logic        m_tlast,
    output int               mismatches,
    output int               pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // Gamma table banks, one per color channel.
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    typedef struct packed {
        logic [31:0]       argb;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } texel_t;

    texel_t texel_queue [$];

    logic [LEVEL_W-1:0] curve_table [NUM_CH][256];

    // Shadow copies of the configuration registers.
    fmt_t               reg_format;
    logic [1:0]         reg_line_mode;
    logic [POS_W-1:0]   reg_x;
    logic [POS_W-1:0]   reg_y;
    logic [COUNT_W-1:0] reg_w;
    logic [COUNT_W-1:0] reg_h;
    logic [COUNT_W-1:0] reg_pitch;
    logic               reg_gamma;

    // Rectangle walk state.
    int unsigned        col_cnt;
    int unsigned        row_cnt;
    logic [ADDR_W-1:0]  row_base;

    int                 fail_tally = 0;

    // Widens one source pixel and passes it through the gamma banks when enabled.
    function automatic logic [31:0] texel_color(logic [31:0] word);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        case (reg_format)
            FMT_BGR565:
            begin
                r = {word[4:0], word[4:2]};
                g = {word[10:5], word[10:9]};
                b = {word[15:11], word[15:13]};
            end
            FMT_BGR555:
            begin
                r = {word[4:0], word[4:2]};
                g = {word[9:5], word[9:7]};
                b = {word[14:10], word[14:12]};
            end
            FMT_BGR444:
            begin
                r = {word[3:0], word[3:0]};
                g = {word[7:4], word[7:4]};
                b = {word[11:8], word[11:8]};
            end
            FMT_ABGR8888:
            begin
                r = word[7:0];
                g = word[15:8];
                b = word[23:16];
            end
            default:
            begin
                // Unknown formats give an all-zero texel, alpha included.
                return '0;
            end
        endcase
        if (reg_gamma)
        begin
            r = curve_table[CH_RED][r];
            g = curve_table[CH_GREEN][g];
            b = curve_table[CH_BLUE][b];
        end
        return ALPHA_OPAQUE | {8'h00, r, g, b};
    endfunction

    // Computes the texel for one pixel and steps the rectangle walk.
    function automatic texel_t predict_texel(logic [31:0] word);
        texel_t      t;
        logic        wide;
        logic [31:0] base;
        int unsigned step;
        int unsigned nxt;
        wide = (reg_format <= FMT_BGR444);
        // A frame starts whenever both counters sit at zero.
        if (col_cnt == 0 && row_cnt == 0)
        begin
            base = reg_y * reg_pitch + reg_x;
            if (wide && reg_line_mode[0])
                base = base + reg_pitch;
            row_base = base[ADDR_W-1:0];
        end
        t.argb = texel_color(word);
        t.addr = ADDR_W'(row_base + col_cnt);
        t.last = 1'b0;
        // Row end; a width of zero behaves like one.
        if (col_cnt + 1 >= reg_w)
        begin
            step = (wide && reg_line_mode[1]) ? 2 : 1;
            nxt = row_cnt + step;
            col_cnt = 0;
            if (nxt >= reg_h)
            begin
                t.last = 1'b1;
                row_cnt = 0;
                row_base = '0;
            end
            else
            begin
                row_cnt = nxt & 32'h3FF;
                row_base = ADDR_W'(row_base + step * reg_pitch);
            end
        end
        else
        begin
            col_cnt = (col_cnt + 1) & 32'h3FF;
        end
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        texel_t want;
        texel_t got;
        if (!rst_n)
        begin
            texel_queue.delete();
            reg_format = FMT_BGR565;
            reg_line_mode = '0;
            reg_x = '0;
            reg_y = '0;
            reg_w = 10'd480;
            reg_h = 10'd272;
            reg_pitch = 10'd512;
            reg_gamma = 1'b0;
            col_cnt = 0;
            row_cnt = 0;
            row_base = '0;
            fail_tally = 0;
            mismatches <= 0;
            pending_results <= 0;
        end
        else
        begin
            // Register writes take effect for the next accepted item.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PIXEL_FORMAT: reg_format = cfg_data[FMT_W-1:0];
                    CFG_LINE_MODE:    reg_line_mode = cfg_data[1:0];
                    CFG_RECT_X:       reg_x = cfg_data[POS_W-1:0];
                    CFG_RECT_Y:       reg_y = cfg_data[POS_W-1:0];
                    CFG_RECT_W:       reg_w = cfg_data;
                    CFG_RECT_H:       reg_h = cfg_data;
                    CFG_ROW_PITCH:    reg_pitch = cfg_data;
                    CFG_GAMMA_ENABLE: reg_gamma = cfg_data[0];
                    default:          ;
                endcase
            end

            // Compare an emitted texel with the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                got.argb = m_tdata[31:0];
                got.addr = m_tdata[49:32];
                got.last = m_tlast;
                if (texel_queue.size() == 0)
                begin
                    $display("%0t: unexpected texel argb %h address %h last %b",
                             $time, got.argb, got.addr, got.last);
                    fail_tally++;
                end
                else
                begin
                    want = texel_queue.pop_front();
                    if (got.argb !== want.argb)
                    begin
                        $display("%0t: texel_argb expected %h actual %h",
                                 $time, want.argb, got.argb);
                        fail_tally++;
                    end
                    if (got.addr !== want.addr)
                    begin
                        $display("%0t: texel_address expected %h actual %h",
                                 $time, want.addr, got.addr);
                        fail_tally++;
                    end
                    if (got.last !== want.last)
                    begin
                        $display("%0t: frame_last expected %b actual %b",
                                 $time, want.last, got.last);
                        fail_tally++;
                    end
                end
            end

            // Accepted input: load a gamma entry or predict a texel.
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACTION_GAMMA)
                begin
                    if (s_tdata[33:32] < NUM_CH)
                        curve_table[s_tdata[33:32]][s_tdata[41:34]] = s_tdata[49:42];
                end
                else
                begin
                    texel_queue.push_back(predict_texel(s_tdata[31:0]));
                end
            end

            pending_results <= texel_queue.size();
            mismatches <= fail_tally;
        end
    end

endmodule

`default_nettype wire

>>> sim/pixel_format_to_argb_gamma_top_tb.sv
// Testbench top for the pixel format converter: clock, reset, register programming,
// pixel and gamma-write stimulus with random idling, and the final verdict.
// Depends on pfag_pkg, pixel_format_to_argb_gamma_top and pfag_checker.
`default_nettype none

module pixel_format_to_argb_gamma_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfag_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 6;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int CYCLE_LIMIT     = 300000;

    localparam fmt_t PROBE_FORMATS [6] = '{FMT_BGR565, FMT_BGR555, FMT_BGR444,
                                           FMT_ABGR8888, FMT_ABGR8888 + 4'd1, 4'hF};
    localparam logic [31:0] PROBE_WORDS [3] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                32'h1234_A5C3};

    typedef struct {
        fmt_t               format;
        logic [1:0]         line_mode;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COUNT_W-1:0] w;
        logic [COUNT_W-1:0] h;
        logic [COUNT_W-1:0] pitch;
        logic               gamma_on;
    } reg_setting_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches;
    int          pending_results;
    int unsigned cycle_count = 0;

    pixel_format_to_argb_gamma_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    pfag_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .pending_results(pending_results)
    );

    always #CLK_HALF clk = ~clk;

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Writes one register; the caller lowers the write enable after the last one.
    task automatic put_reg(input cfg_reg_t idx, input logic [9:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(input reg_setting_t rs);
        put_reg(CFG_PIXEL_FORMAT, 10'(rs.format));
        put_reg(CFG_LINE_MODE, 10'(rs.line_mode));
        put_reg(CFG_RECT_X, 10'(rs.x));
        put_reg(CFG_RECT_Y, 10'(rs.y));
        put_reg(CFG_RECT_W, rs.w);
        put_reg(CFG_RECT_H, rs.h);
        put_reg(CFG_ROW_PITCH, rs.pitch);
        put_reg(CFG_GAMMA_ENABLE, 10'(rs.gamma_on));
        cfg_we <= 1'b0;
    endtask

    // Presents one item after a random idle stretch and holds it until accepted.
    task automatic offer_item(input logic action, input logic [31:0] word,
                              input logic [1:0] channel, input logic [7:0] level,
                              input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= action;
        s_tdata <= {6'b0, value, level, channel, word};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic offer_pixel(input logic [31:0] word);
        offer_item(ACTION_PIXEL, word, '0, '0, '0);
    endtask

    // Stops sending and lets every predicted texel arrive, plus the pipeline depth.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
    endtask

    // Register setting of one random phase; the first few pin the extremes.
    function automatic reg_setting_t pick_setting(int phase);
        reg_setting_t rs;
        rs.format = ($urandom_range(9) < 8) ? fmt_t'($urandom_range(3))
                                            : fmt_t'($urandom_range(4, 15));
        rs.line_mode = 2'($urandom_range(3));
        rs.x = 9'($urandom_range(511));
        rs.y = 9'($urandom_range(511));
        rs.w = ($urandom_range(9) == 0) ? 10'd512 : 10'($urandom_range(1, 12));
        rs.h = 10'($urandom_range(1, 8));
        rs.pitch = 10'($urandom_range(1, 512));
        rs.gamma_on = 1'($urandom_range(1));
        case (phase)
            0:
            begin
                rs = '{FMT_BGR565, 2'd0, 9'd0, 9'd0, 10'd1, 10'd1, 10'd1, 1'b0};
            end
            1:
            begin
                rs = '{FMT_ABGR8888, 2'd3, 9'd511, 9'd511, 10'd512, 10'd512, 10'd512, 1'b1};
            end
            2:
            begin
                // Zero width, height and pitch act as one, one and coinciding rows.
                rs = '{FMT_BGR555, 2'd1, 9'd511, 9'd511, 10'd0, 10'd0, 10'd0, 1'b1};
            end
            3:
            begin
                // Line skip with a start one line lower, wrapping past the texture end.
                rs = '{FMT_BGR444, 2'd3, 9'd300, 9'd511, 10'd7, 10'd9, 10'd512, 1'b1};
            end
            4:
            begin
                rs.format = FMT_BGR565;
                rs.line_mode = 2'd2;
            end
            5:
            begin
                rs.format = 4'hF;
            end
            default: ;
        endcase
        return rs;
    endfunction

    initial
    begin
        reg_setting_t rs;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every format, known and unknown, with extreme pixel words.
        rs = '{FMT_BGR565, 2'd0, 9'd5, 9'd3, 10'd4, 10'd3, 10'd16, 1'b0};
        foreach (PROBE_FORMATS[f])
        begin
            rs.format = PROBE_FORMATS[f];
            program_regs(rs);
            foreach (PROBE_WORDS[i])
                offer_pixel(PROBE_WORDS[i]);
            wait_drained();
        end

        // Directed gamma writes, one to the nonexistent fourth channel.
        offer_item(ACTION_GAMMA, '0, 2'(NUM_CH), 8'hFF, 8'hFF);
        offer_item(ACTION_GAMMA, '0, 2'd0, 8'h00, 8'hFF);
        offer_item(ACTION_GAMMA, '0, 2'(NUM_CH - 1), 8'hFF, 8'h00);
        offer_pixel(32'hA5A5_5A5A);
        wait_drained();

        // Fill the whole gamma table before it may ever be enabled.
        set_idling(1);
        for (int ch = 0; ch < NUM_CH; ch++)
            for (int lvl = 0; lvl < 256; lvl++)
                offer_item(ACTION_GAMMA, 32'($urandom), 2'(ch), 8'(lvl),
                           8'($urandom_range(255)));
        wait_drained();

        // Random phases: mostly pixels, some gamma rewrites, each phase
        // with its own register setting and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            program_regs(pick_setting(p));
            set_idling(p);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(9) == 0)
                    offer_item(ACTION_GAMMA, 32'($urandom), 2'($urandom_range(3)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                else
                    offer_pixel(32'($urandom));
            end
            wait_drained();
        end

        if (mismatches == 0 && pending_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
